// File: rtl/bibn_pkg.sv
// Package for the branching-number block: sizes, register indexes, shared types
// and the ring crossing count. Used by every module of the block; depends on nothing.
package bibn_pkg;

	// Frame limits
	localparam int MAX_WIDTH = 1024;
	localparam int WID_W     = 11;                 // width register
	localparam int HGT_W     = 16;                 // height register
	localparam int COL_W     = $clog2(MAX_WIDTH);  // column / line store address
	localparam int ROW_W     = 16;                 // saturating input row
	localparam int POS_W     = 26;                 // result position counter
	localparam int CNT_W     = 4;                  // branch count field
	localparam int DIV_CNT_W = $clog2(POS_W);
	localparam int OQ_DEPTH  = 3;                  // output queue entries
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
	localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);

	localparam logic [WID_W-1:0] MAX_WIDTH_L  = WID_W'(MAX_WIDTH);
	localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
	localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(1);
	localparam logic [ROW_W-1:0] ROW_SAT      = '1;
	localparam logic [CNT_W-1:0] BACKGROUND   = '1;  // -1 in two's complement

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Per-request control passed from the position logic to the window stage
	typedef struct packed {
		logic emit;    // request produces a result
		logic last;    // result closes the frame
		logic mask_l;  // result pixel on the left border
		logic mask_r;  // right border
		logic mask_t;  // top border
		logic mask_b;  // bottom border
		logic degen;   // width or height below two
	} pos_ctl_t;

	// One result request
	typedef struct packed {
		logic             frame_last;
		logic [CNT_W-1:0] count;
	} res_item_t;

	// 0-to-1 transitions around the ring, bit 0 follows bit 7
	function automatic logic [2:0] ring_cross(input logic [7:0] ring);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (ring[i] && !ring[(i + 7) % 8]) begin
				n = n + 3'd1;
			end
		end
		return n;
	endfunction

endpackage

// File: rtl/bibn_div.sv
// Restoring divider, one quotient bit a cycle: splits the result position into
// row and column after a configuration write. Depends on bibn_pkg.
module bibn_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bibn_pkg::POS_W-1:0]    dividend,
	input  logic [bibn_pkg::WID_W-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [bibn_pkg::POS_W-1:0]    quotient,
	output logic [bibn_pkg::WID_W-1:0]    remainder
);

	logic                            busy_q;
	logic                            done_q;
	logic [bibn_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [bibn_pkg::POS_W-1:0]      quo_q;
	logic [bibn_pkg::WID_W-1:0]      rem_q;
	logic [bibn_pkg::WID_W-1:0]      div_q;
	logic [bibn_pkg::WID_W:0]        trial;
	logic [bibn_pkg::WID_W:0]        diff;
	logic                            ge;

	// One trial subtraction per cycle
	assign trial = {rem_q, quo_q[bibn_pkg::POS_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == bibn_pkg::DIV_CNT_W'(bibn_pkg::POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bibn_pkg::POS_W-2:0], ge};
			rem_q <= ge ? diff[bibn_pkg::WID_W-1:0] : trial[bibn_pkg::WID_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");

endmodule

// File: rtl/bibn_line.sv
// Line store (read-modify-write, registered read) and 3x3 window stage that forms
// the masked ring and its crossing count. Depends on bibn_pkg.
module bibn_line (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  logic [bibn_pkg::COL_W-1:0]    col,
	input  logic                          px,
	input  bibn_pkg::pos_ctl_t            ctl,
	output logic                          s1_valid,
	output logic                          res_valid,
	output bibn_pkg::res_item_t           res
);

	// Entry: bit 1 two rows back, bit 0 previous row
	logic [1:0]                    mem [bibn_pkg::MAX_WIDTH];

	logic                          valid_s1;
	logic [bibn_pkg::COL_W-1:0]    col_s1;
	logic                          px_s1;
	bibn_pkg::pos_ctl_t            ctl_s1;
	logic [1:0]                    rd_s1;
	logic                          fwd_s1;
	logic [1:0]                    fwd_data_s1;
	logic [8:0]                    win_q;

	logic [1:0]                    ent;
	logic [1:0]                    wr_data;
	logic [8:0]                    win_new;
	logic [8:0]                    win_m;
	logic [7:0]                    ring;

	// Entry seen by the stage: forwarded when the previous request wrote it
	assign ent     = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_data = {ent[0], px_s1};
	// Window columns: 8..6 left, 5..3 centre, 2..0 right; down, centre, up in each
	assign win_new = {win_q[5:0], px_s1, ent[0], ent[1]};

	// Memory port
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem[col_s1] <= wr_data;
		end
		if (acc) begin
			rd_s1 <= mem[col];
		end
	end

	// Stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			win_q    <= '0;
		end else begin
			valid_s1 <= acc;
			fwd_s1   <= acc && valid_s1 && (col == col_s1);
			if (valid_s1) begin
				win_q <= ctl_s1.last ? 9'd0 : win_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1      <= col;
			px_s1       <= px;
			ctl_s1      <= ctl;
			fwd_data_s1 <= wr_data;
		end
	end

	// Border masking
	always_comb begin
		win_m = win_new;
		if (ctl_s1.mask_l) win_m = win_m & ~9'h1C0;
		if (ctl_s1.mask_r) win_m = win_m & ~9'h007;
		if (ctl_s1.mask_t) win_m = win_m & ~9'h049;
		if (ctl_s1.mask_b) win_m = win_m & ~9'h124;
	end

	// Ring: right, upper-right, up, upper-left, left, lower-left, down, lower-right
	assign ring = {win_m[2], win_m[5], win_m[8], win_m[7],
	               win_m[6], win_m[3], win_m[0], win_m[1]};

	assign s1_valid       = valid_s1;
	assign res_valid      = valid_s1 && ctl_s1.emit;
	assign res.frame_last = ctl_s1.last;
	assign res.count      = (!ctl_s1.degen && win_m[4]) ?
	                        {1'b0, bibn_pkg::ring_cross(ring)} : bibn_pkg::BACKGROUND;

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1) else $error("forward without request");
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctl_s1.last |=> win_q == 9'd0) else $error("window not cleared");
	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> win_q === $past(win_q)) else $error("window moved while idle");

endmodule

// File: rtl/bibn_ofifo.sv
// Three-entry result queue between the window stage and the output channel.
// Depends on bibn_pkg.
module bibn_ofifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  bibn_pkg::res_item_t              din,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bibn_pkg::res_item_t              dout,
	output logic [bibn_pkg::OQ_CNT_W-1:0]    count
);

	bibn_pkg::res_item_t                 store_q [bibn_pkg::OQ_DEPTH];
	logic [bibn_pkg::OQ_PTR_W-1:0]       wr_q;
	logic [bibn_pkg::OQ_PTR_W-1:0]       rd_q;
	logic [bibn_pkg::OQ_CNT_W-1:0]       count_q;
	logic                                pop;

	assign pop = out_valid && out_ready;

	// Pointer wrap
	function automatic logic [bibn_pkg::OQ_PTR_W-1:0] nxt(
		input logic [bibn_pkg::OQ_PTR_W-1:0] p);
		return (p == bibn_pkg::OQ_PTR_W'(bibn_pkg::OQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop)  rd_q <= nxt(rd_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= din;
		end
	end

	assign out_valid = count_q != '0;
	assign dout      = store_q[rd_q];
	assign count     = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != bibn_pkg::OQ_CNT_W'(bibn_pkg::OQ_DEPTH))
		else $error("result queue overflow");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("pop count");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("push count");

endmodule

// File: rtl/binary_image_branching_number.sv
// Top level of the branching-number block: configuration, frame position
// counters and ready logic. Depends on bibn_pkg, bibn_div, bibn_line, bibn_ofifo.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    pixel_bit, flush
//   output    out_valid / out_ready  branch_count (signed), frame_last
//   config    cfg_write              cfg_index, cfg_data
//
// One request per cycle while in_ready is high; a result goes from the window
// stage into the result queue. The line store is one 1024x2 memory read at
// accept and written back the next cycle. After reset no clearing pass is
// needed. After a configuration write in_ready stays low while the divider
// re-derives the output row and column; otherwise it drops only when the
// three-entry result queue could be overfilled by a stalled output.
module binary_image_branching_number (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          pixel_bit,
	input  logic                          flush,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [3:0]             branch_count,
	output logic                          frame_last,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [15:0]                   cfg_data
);

	logic [bibn_pkg::WID_W-1:0]     width_q;
	logic [bibn_pkg::HGT_W-1:0]     height_q;
	logic [bibn_pkg::WID_W-1:0]     w_eff;
	logic [bibn_pkg::HGT_W-1:0]     h_eff;
	logic [bibn_pkg::POS_W-1:0]     total_q;

	logic [bibn_pkg::COL_W-1:0]     col_q;
	logic [bibn_pkg::ROW_W-1:0]     row_q;
	logic [bibn_pkg::POS_W-1:0]     e_q;
	logic [bibn_pkg::COL_W-1:0]     ec_q;
	logic [bibn_pkg::POS_W-1:0]     er_q;
	logic                           pend_q;

	logic                           acc;
	logic                           px;
	logic [bibn_pkg::WID_W-1:0]     col_inc;
	logic                           col_wrap;
	logic [bibn_pkg::POS_W:0]       e_inc;
	logic [bibn_pkg::WID_W-1:0]     ec_inc;
	logic                           ec_wrap;
	logic [bibn_pkg::POS_W:0]       er_inc;
	bibn_pkg::pos_ctl_t             ctl;

	logic                           div_busy;
	logic                           div_done;
	logic [bibn_pkg::POS_W-1:0]     div_quo;
	logic [bibn_pkg::WID_W-1:0]     div_rem;

	logic                           s1_valid;
	logic                           res_valid;
	bibn_pkg::res_item_t            res;
	bibn_pkg::res_item_t            dout;
	logic [bibn_pkg::OQ_CNT_W-1:0]  oq_count;
	logic [bibn_pkg::OQ_CNT_W:0]    credit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bibn_pkg::WIDTH_RESET;
			height_q <= bibn_pkg::HEIGHT_RESET;
			pend_q   <= 1'b0;
		end else begin
			pend_q <= cfg_write;
			if (cfg_write) begin
				case (cfg_index)
					bibn_pkg::REG_WIDTH:  width_q  <= cfg_data[bibn_pkg::WID_W-1:0];
					bibn_pkg::REG_HEIGHT: height_q <= cfg_data;
					default:              width_q  <= width_q;
				endcase
			end
		end
	end

	// Effective frame size and pixel count
	assign w_eff = (width_q == '0) ? bibn_pkg::WID_W'(1) :
	               (width_q > bibn_pkg::MAX_WIDTH_L) ? bibn_pkg::MAX_WIDTH_L : width_q;
	assign h_eff = (height_q == '0) ? bibn_pkg::HGT_W'(1) : height_q;

	always_ff @(posedge clk) begin
		total_q <= bibn_pkg::POS_W'(w_eff) * bibn_pkg::POS_W'(h_eff);
	end

	// Ready: no divider work and room for every result in flight
	assign credit   = {1'b0, oq_count} + {{bibn_pkg::OQ_CNT_W{1'b0}}, s1_valid};
	assign in_ready = !(pend_q || div_busy || div_done) &&
	                  (credit < (bibn_pkg::OQ_CNT_W + 1)'(bibn_pkg::OQ_DEPTH));
	assign acc      = in_valid && in_ready;
	assign px       = flush ? 1'b0 : pixel_bit;

	// Input and result position decisions
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign col_wrap = col_inc >= w_eff;
	assign e_inc    = {1'b0, e_q} + 1'b1;
	assign ec_inc   = {1'b0, ec_q} + 1'b1;
	assign ec_wrap  = ec_inc >= w_eff;
	assign er_inc   = {1'b0, er_q} + 1'b1;

	always_comb begin
		ctl.emit   = (row_q >= bibn_pkg::ROW_W'(2)) ||
		             (row_q == bibn_pkg::ROW_W'(1) && col_q != '0);
		ctl.last   = ctl.emit && (e_inc >= {1'b0, total_q});
		ctl.mask_l = ec_q == '0;
		ctl.mask_r = ec_wrap;
		ctl.mask_t = er_q == '0;
		ctl.mask_b = er_inc >= (bibn_pkg::POS_W + 1)'(h_eff);
		ctl.degen  = (w_eff < bibn_pkg::WID_W'(2)) || (h_eff < bibn_pkg::HGT_W'(2));
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			e_q   <= '0;
			ec_q  <= '0;
			er_q  <= '0;
		end else if (div_done) begin
			ec_q <= div_rem[bibn_pkg::COL_W-1:0];
			er_q <= div_quo;
		end else if (acc) begin
			if (ctl.last) begin
				col_q <= '0;
				row_q <= '0;
				e_q   <= '0;
				ec_q  <= '0;
				er_q  <= '0;
			end else begin
				col_q <= col_wrap ? '0 : col_inc[bibn_pkg::COL_W-1:0];
				if (col_wrap && row_q != bibn_pkg::ROW_SAT) begin
					row_q <= row_q + 1'b1;
				end
				if (ctl.emit) begin
					e_q  <= e_inc[bibn_pkg::POS_W-1:0];
					ec_q <= ec_wrap ? '0 : ec_inc[bibn_pkg::COL_W-1:0];
					if (ec_wrap) begin
						er_q <= er_inc[bibn_pkg::POS_W-1:0];
					end
				end
			end
		end
	end

	bibn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pend_q),
		.dividend  (e_q),
		.divisor   (w_eff),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	bibn_line u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.col       (col_q),
		.px        (px),
		.ctl       (ctl),
		.s1_valid  (s1_valid),
		.res_valid (res_valid),
		.res       (res)
	);

	bibn_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.din       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (dout),
		.count     (oq_count)
	);

	assign branch_count = $signed(dout.count);
	assign frame_last   = dout.frame_last;

	a_acc_stage: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid) else $error("request lost before window stage");
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !in_ready) else $error("request taken during recompute");
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && ctl.last |=> e_q == '0 && col_q == '0 && row_q == '0)
		else $error("counters not cleared at frame end");

endmodule
